// ----- hw/rtl/omw_pkg.sv -----
// Shared types, constants and the sine table for the omni wheel speed mixer.
// Used by omw_front, omw_queue, omw_back and the top level.
package omw_pkg;

  localparam int SPEED_W  = 14;
  localparam int HEAD_W   = 16;
  localparam int TICK_W   = 16;
  localparam int ACCEL_W  = 10;
  localparam int DBAND_W  = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int ANGLE_W  = 9;

  localparam int SPEED_LIMIT = 4096;
  localparam int STEP_CAP    = 2 * SPEED_LIMIT;

  localparam logic [ACCEL_W-1:0] ACCEL_RESET = ACCEL_W'(70);
  localparam logic [DBAND_W-1:0] DBAND_RESET = DBAND_W'(20);

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = CFG_IDX_W'(1);

  // Heading reduction: bias to a positive value that is a multiple of 360,
  // then take the quotient by a reciprocal multiply. The reciprocal error is
  // smaller than 1/360 over the biased range, so no correction is needed.
  localparam int MOD_BIAS  = 92 * 360;
  localparam int MOD_RECIP = 46604;
  localparam int MOD_SHIFT = 24;

  // Angle of each wheel is (offset - 180 - heading) modulo 360.
  localparam logic [ANGLE_W-1:0] ANGLE_ONE   = ANGLE_W'((45 - 180 + 720) % 360);
  localparam logic [ANGLE_W-1:0] ANGLE_TWO   = ANGLE_W'((135 - 180 + 720) % 360);
  localparam logic [ANGLE_W-1:0] ANGLE_THREE = ANGLE_W'((-135 - 180 + 720) % 360);
  localparam logic [ANGLE_W-1:0] ANGLE_FOUR  = ANGLE_W'((-45 - 180 + 720) % 360);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_write_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        heading_mod;
    logic signed [SPEED_W-1:0] cmd;
    logic signed [SPEED_W-1:0] ramp;
  } queue_entry_t;

  // Quarter-wave sine, 1.0 = 32768, one entry per whole degree.
  localparam logic [15:0] SINE_Q [0:90] = '{
    16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
    16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927, 16'd8481,
    16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275,
    16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
    16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795, 16'd19261,
    16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926, 16'd22348,
    16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730, 16'd25102,
    16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166, 16'd27482,
    16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
    16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792, 16'd30983,
    16'd31164, 16'd31337, 16'd31499, 16'd31651, 16'd31795, 16'd31928, 16'd32052,
    16'd32166, 16'd32271, 16'd32365, 16'd32449, 16'd32524, 16'd32588, 16'd32643,
    16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  function automatic logic [15:0] sine_lookup(input logic [6:0] idx);
    logic [15:0] val;
    if (idx > 7'd90) begin
      val = 16'd0;
    end else begin
      val = SINE_Q[idx];
    end
    return val;
  endfunction

endpackage

// ----- hw/rtl/omni_wheel_speed_mixer_top.sv -----
// Omni wheel speed mixer: four-wheel kinematics with a slew-limited ramp.
// Instantiates omw_front, omw_queue and omw_back; depends on omw_pkg.
//
// Usage:
//   s_* is the request stream: heading, commanded speed and elapsed ticks.
//   m_* is the result stream: four wheel speeds and the ramped speed.
//   cfg_we/cfg_index/cfg_data write accel_per_tick (index 0) and deadband
//   (index 1); other indexes are ignored. Write only when idle.
// Throughput: one request per cycle, sustained, while m_tready is high. The
//   front end computes the heading reduction and the ramp in the accepting
//   cycle; the back end does the four table lookups and multiplies
//   combinationally into the output register.
// Path: an accepted request is first written into the queue, then popped
//   into the output register, which drives m_tvalid.
// Stalls: when m_tready is low the result holds; the two-entry queue keeps
//   taking requests until it fills, then s_tready drops.
// Reset: rst (synchronous) empties the queue and output, clears the ramp to
//   zero and sets accel_per_tick to 70 and deadband to 20.
module omni_wheel_speed_mixer_top import omw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // heading_deg[15:0], commanded_speed[29:16], elapsed_ticks[45:30], zero pad
  input  logic [47:0]          s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // wheel_one[13:0], wheel_two[27:14], wheel_three[41:28], wheel_four[55:42],
  // ramped_speed[69:56], zero pad
  output logic [71:0]          m_tdata
);

  cfg_write_t   cfg;
  logic         push_valid;
  logic         push_ready;
  queue_entry_t push_data;
  logic         pop_valid;
  logic         pop_ready;
  queue_entry_t pop_data;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  omw_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .heading_deg     ($signed(s_tdata[15:0])),
    .commanded_speed ($signed(s_tdata[29:16])),
    .elapsed_ticks   (s_tdata[45:30]),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  omw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  omw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ----- hw/rtl/omw_front.sv -----
// Front end: accepts requests, saturates the command, reduces the heading
// modulo 360 and updates the slew-limited ramp. Holds the configuration.
// Depends on omw_pkg.
module omw_front import omw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_write_t                cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [HEAD_W-1:0]  heading_deg,
  input  logic signed [SPEED_W-1:0] commanded_speed,
  input  logic [TICK_W-1:0]         elapsed_ticks,
  output logic                      push_valid,
  input  logic                      push_ready,
  output queue_entry_t              push_data
);

  localparam logic signed [15:0] LIMIT  = 16'(SPEED_LIMIT);
  localparam logic signed [15:0] NLIMIT = -16'(SPEED_LIMIT);

  logic [ACCEL_W-1:0]        accel_per_tick;
  logic [DBAND_W-1:0]        deadband;
  logic signed [SPEED_W-1:0] ramp_level;
  logic signed [SPEED_W-1:0] ramp_level_next;

  logic                      accept;
  logic signed [SPEED_W-1:0] cmd_sat;
  logic [SPEED_W-1:0]        cmd_mag;
  logic [16:0]               biased;
  logic [32:0]               quot_prod;
  logic [7:0]                quot;
  logic [16:0]               remainder;
  logic [25:0]               step_prod;
  logic [15:0]               step;
  logic signed [15:0]        r_ext;
  logic signed [15:0]        c_ext;
  logic signed [15:0]        r_try;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    if (commanded_speed > SPEED_W'(SPEED_LIMIT)) begin
      cmd_sat = SPEED_W'(SPEED_LIMIT);
    end else if (commanded_speed < -SPEED_W'(SPEED_LIMIT)) begin
      cmd_sat = -SPEED_W'(SPEED_LIMIT);
    end else begin
      cmd_sat = commanded_speed;
    end
    cmd_mag = cmd_sat[SPEED_W-1] ? SPEED_W'(-cmd_sat) : SPEED_W'(cmd_sat);
  end

  always_comb begin
    biased    = {heading_deg[HEAD_W-1], heading_deg} + 17'(MOD_BIAS);
    quot_prod = 33'(biased) * 33'(MOD_RECIP);
    quot      = quot_prod[MOD_SHIFT +: 8];
    remainder = biased - 17'(quot) * 17'd360;
  end

  // The step only needs to reach twice the limit; the ramp clamps after it.
  always_comb begin
    step_prod = 26'(accel_per_tick) * 26'(elapsed_ticks);
    if (step_prod > 26'(STEP_CAP)) begin
      step = 16'(STEP_CAP);
    end else begin
      step = step_prod[15:0];
    end
  end

  always_comb begin
    r_ext = 16'(ramp_level);
    c_ext = 16'(cmd_sat);
    r_try = r_ext;
    ramp_level_next = ramp_level;
    if ({1'b0, cmd_mag} < {(SPEED_W + 1 - DBAND_W)'(0), deadband}) begin
      ramp_level_next = '0;
    end else if (c_ext > r_ext) begin
      if (r_ext != 16'sd0) begin
        r_try = r_ext + $signed(step);
        if (r_try > LIMIT) r_try = LIMIT;
        if (r_try > c_ext) r_try = c_ext;
      end
      if (r_try == 16'sd0) r_try = 16'sd1;
      ramp_level_next = SPEED_W'(r_try);
    end else if (c_ext < r_ext) begin
      if (r_ext != 16'sd0) begin
        r_try = r_ext - $signed(step);
        if (r_try < NLIMIT) r_try = NLIMIT;
        if (r_try < c_ext) r_try = c_ext;
      end
      if (r_try == 16'sd0) r_try = -16'sd1;
      ramp_level_next = SPEED_W'(r_try);
    end
  end

  always_comb begin
    push_data.heading_mod = remainder[ANGLE_W-1:0];
    push_data.cmd         = cmd_sat;
    push_data.ramp        = ramp_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_per_tick <= ACCEL_RESET;
      deadband       <= DBAND_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_ACCEL:    accel_per_tick <= cfg.data[ACCEL_W-1:0];
        CFG_DEADBAND: deadband       <= cfg.data[DBAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_level <= '0;
    end else if (accept) begin
      ramp_level <= ramp_level_next;
    end
  end

`ifndef ASSERT_OFF
  a_ramp_in_range: assert property (@(posedge clk) disable iff (rst)
    (ramp_level <= SPEED_W'(SPEED_LIMIT)) && (ramp_level >= -SPEED_W'(SPEED_LIMIT)))
    else $error("ramp level outside the speed limit");
  a_ramp_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(ramp_level))
    else $error("ramp level changed without an accepted request");
`endif

endmodule

// ----- hw/rtl/omw_queue.sv -----
// Two-entry queue that decouples the front end from the wheel mixing back end.
// Depends on omw_pkg.
module omw_queue import omw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  queue_entry_t push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output queue_entry_t pop_data
);

  queue_entry_t      entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");
`endif

endmodule

// ----- hw/rtl/omw_back.sv -----
// Back end: looks up the sine of each wheel angle, multiplies by the command
// and registers the result request. Depends on omw_pkg.
module omw_back import omw_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  queue_entry_t            pop_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [5*SPEED_W+1:0]    out_data
);

  logic                      valid;
  logic signed [SPEED_W-1:0] wheel [4];
  logic signed [SPEED_W-1:0] ramp;
  logic signed [SPEED_W-1:0] mixed [4];
  logic [ANGLE_W-1:0]        offsets [4];
  logic                      take;

  // Truncation toward zero is done on magnitudes, then the sign is applied.
  function automatic logic signed [SPEED_W-1:0] mix(input logic [ANGLE_W-1:0] offset,
                                                   input logic [ANGLE_W-1:0] hmod,
                                                   input logic signed [SPEED_W-1:0] cmd);
    logic [ANGLE_W:0]   diff;
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] idx;
    logic               neg;
    logic [SPEED_W-2:0] cmag;
    logic [28:0]        prod;
    logic [SPEED_W-1:0] quo;
    diff = {1'b0, offset} - {1'b0, hmod};
    if (diff[ANGLE_W]) begin
      diff = diff + (ANGLE_W + 1)'(360);
    end
    angle = diff[ANGLE_W-1:0];
    if (angle <= ANGLE_W'(90)) begin
      idx = angle;
      neg = 1'b0;
    end else if (angle <= ANGLE_W'(180)) begin
      idx = ANGLE_W'(180) - angle;
      neg = 1'b0;
    end else if (angle <= ANGLE_W'(270)) begin
      idx = angle - ANGLE_W'(180);
      neg = 1'b1;
    end else begin
      idx = ANGLE_W'(360) - angle;
      neg = 1'b1;
    end
    cmag = cmd[SPEED_W-1] ? (SPEED_W-1)'(-cmd) : (SPEED_W-1)'(cmd);
    prod = 29'(sine_lookup(idx[6:0])) * 29'(cmag);
    quo  = prod[28:15];
    return (neg ^ cmd[SPEED_W-1]) ? SPEED_W'(-quo) : SPEED_W'(quo);
  endfunction

  assign offsets[0] = ANGLE_ONE;
  assign offsets[1] = ANGLE_TWO;
  assign offsets[2] = ANGLE_THREE;
  assign offsets[3] = ANGLE_FOUR;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mixed[k] = mix(offsets[k], pop_data.heading_mod, pop_data.cmd);
    end
  end

  assign pop_ready = !valid || out_ready;
  assign take      = pop_valid && pop_ready;
  assign out_valid = valid;
  assign out_data  = {2'b00, ramp, wheel[3], wheel[2], wheel[1], wheel[0]};

  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < 4; k++) begin
        wheel[k] <= mixed[k];
      end
      ramp <= pop_data.ramp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop_ready) begin
      valid <= pop_valid;
    end
  end

`ifndef ASSERT_OFF
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (valid && !out_ready) |-> !take)
    else $error("queue popped while the result register is stalled");
`endif

endmodule
